/* design/ipv4dq_pkg.sv */
// ----------------------------------------------------------------------------
// ipv4dq_pkg
// Shared types, character codes and error codes of the dotted-quad checker.
// ----------------------------------------------------------------------------
`default_nettype none

package ipv4dq_pkg;

    // default limit on string length
    localparam int MAX_CHARS_DEFAULT = 15;

    // character codes
    localparam logic [7:0] DOT_CHAR   = 8'h2E;
    localparam logic [7:0] DIGIT_LOW  = 8'h30;
    localparam logic [7:0] DIGIT_HIGH = 8'h39;

    // section and dot limits
    localparam logic [8:0] SECTION_MAX = 9'd255;
    localparam logic [8:0] SECTION_SAT = 9'd256;
    localparam logic [3:0] DOTS_NEEDED = 4'd3;
    localparam logic [3:0] DOTS_SAT    = 4'd15;

    // error codes
    localparam logic [2:0] ERR_NONE        = 3'd0;
    localparam logic [2:0] ERR_LEADING_DOT = 3'd1;
    localparam logic [2:0] ERR_SECTION     = 3'd2;
    localparam logic [2:0] ERR_BAD_CHAR    = 3'd3;
    localparam logic [2:0] ERR_TOO_LONG    = 3'd4;
    localparam logic [2:0] ERR_FINAL       = 3'd5;

    // per-string scan state (character count kept apart, its width follows MAX_CHARS)
    typedef struct packed {
        logic [3:0] dot_count;
        logic [8:0] section_value;
        logic [2:0] error_code;
        logic       at_first_char;
    } scan_st_t;

    localparam scan_st_t SCAN_RESET = '{
        dot_count:     4'd0,
        section_value: 9'd0,
        error_code:    ERR_NONE,
        at_first_char: 1'b1
    };

    // verdict of one string
    typedef struct packed {
        logic       address_ok;
        logic [2:0] error_kind;
    } verdict_t;

endpackage

`default_nettype wire

/* design/ipv4dq_step.sv */
// ----------------------------------------------------------------------------
// ipv4dq_step
// Next-state and verdict logic for one character item of the checker.
// ----------------------------------------------------------------------------
`default_nettype none

module ipv4dq_step #(
    parameter int MAX_CHARS = ipv4dq_pkg::MAX_CHARS_DEFAULT,
    localparam int CW = $clog2(MAX_CHARS + 2)
) (
    input  wire logic [7:0]           character,
    input  wire logic                 has_character,
    input  wire logic                 last,
    input  wire ipv4dq_pkg::scan_st_t st,
    input  wire logic [CW-1:0]        char_count,
    output ipv4dq_pkg::scan_st_t      st_next,
    output logic [CW-1:0]             char_count_next,
    output ipv4dq_pkg::verdict_t      verdict
);
    import ipv4dq_pkg::*;

    logic [11:0] prod;
    logic        counted;
    logic [2:0]  verdict_code;

    // section * 10 + digit, the low nibble of an ascii digit is its value
    assign prod = {st.section_value, 3'b000}
                + {2'b00, st.section_value, 1'b0}
                + {8'h00, character[3:0]};

    // character update, then verdict, then restart on the last item
    always_comb
    begin
        st_next         = st;
        char_count_next = char_count;
        counted         = 1'b0;
        if (has_character)
        begin
            st_next.at_first_char = 1'b0;
            if (st.error_code == ERR_NONE)
            begin
                if (character == DOT_CHAR)
                begin
                    if (st.at_first_char)
                    begin
                        st_next.error_code = ERR_LEADING_DOT;
                    end
                    else
                    begin
                        if (st.dot_count != DOTS_SAT)
                        begin
                            st_next.dot_count = st.dot_count + 4'd1;
                        end
                        if (st.section_value > SECTION_MAX)
                        begin
                            st_next.error_code = ERR_SECTION;
                        end
                        else
                        begin
                            st_next.section_value = '0;
                            counted               = 1'b1;
                        end
                    end
                end
                else if (character inside {[DIGIT_LOW:DIGIT_HIGH]})
                begin
                    st_next.section_value = (prod > {3'b000, SECTION_SAT}) ?
                                            SECTION_SAT : prod[8:0];
                    counted = 1'b1;
                end
                else
                begin
                    st_next.error_code = ERR_BAD_CHAR;
                end

                // length check after the character is taken
                if (counted)
                begin
                    if (char_count <= CW'(MAX_CHARS))
                    begin
                        char_count_next = char_count + CW'(1);
                    end
                    if (char_count_next > CW'(MAX_CHARS))
                    begin
                        st_next.error_code = ERR_TOO_LONG;
                    end
                end
            end
        end

        // final check on the state left by this item
        verdict_code = st_next.error_code;
        if ((verdict_code == ERR_NONE) &&
            !((st_next.section_value <= SECTION_MAX) && (st_next.dot_count == DOTS_NEEDED)))
        begin
            verdict_code = ERR_FINAL;
        end
        verdict.address_ok = (verdict_code == ERR_NONE);
        verdict.error_kind = verdict_code;

        if (last)
        begin
            st_next         = SCAN_RESET;
            char_count_next = '0;
        end
    end

endmodule

`default_nettype wire

/* design/ipv4_dotted_quad_checker.sv */
// ----------------------------------------------------------------------------
// ipv4_dotted_quad_checker
// Checks an IPv4 dotted-decimal string that arrives one character per item.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_ready) carries one character per item with
//   has_character and last; an item with has_character low and last high ends
//   an empty string. Output channel (out_valid / out_ready) carries one item,
//   address_ok and error_kind, for each input item marked last.
//   Path: an accepted item sits in the input register and is then evaluated
//   into the state and result registers, and its verdict is visible from
//   the result register.
//   Throughput: one item per cycle unless a last item waits for the result
//   register; the section update (multiply by ten, saturate) and the compares
//   lie between the input register and the state and result registers.
//   Stalls: characters not marked last keep flowing while a verdict waits;
//   an item marked last holds in the input register until the result
//   register is free, and in_ready drops only while it holds.
//   Reset: all state returns to the start of a string, both channels empty.
//   After each verdict the scan state restarts for the next string.
// ----------------------------------------------------------------------------
`default_nettype none

module ipv4_dotted_quad_checker #(
    parameter int MAX_CHARS = ipv4dq_pkg::MAX_CHARS_DEFAULT
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [7:0] character,
    input  wire logic       has_character,
    input  wire logic       last,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic            address_ok,
    output logic [2:0]      error_kind
);
    import ipv4dq_pkg::*;

    localparam int CW = $clog2(MAX_CHARS + 2);

    logic          s1_valid_reg;
    logic          s1_valid_next;
    logic [7:0]    s1_char_reg;
    logic          s1_has_reg;
    logic          s1_last_reg;
    scan_st_t      st_reg;
    scan_st_t      st_next;
    logic [CW-1:0] char_count_reg;
    logic [CW-1:0] char_count_next;
    verdict_t      verdict;
    logic          out_valid_reg;
    logic          out_valid_next;
    verdict_t      out_reg;
    logic          in_fire;
    logic          s1_advance;

    // handshake
    assign s1_advance = s1_valid_reg && (!s1_last_reg || !out_valid_reg || out_ready);
    assign in_ready   = !s1_valid_reg || s1_advance;
    assign in_fire    = in_valid && in_ready;

    // per-character logic
    ipv4dq_step #(
        .MAX_CHARS(MAX_CHARS)
    ) u_step (
        .character       (s1_char_reg),
        .has_character   (s1_has_reg),
        .last            (s1_last_reg),
        .st              (st_reg),
        .char_count      (char_count_reg),
        .st_next         (st_next),
        .char_count_next (char_count_next),
        .verdict         (verdict)
    );

    // input register
    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_fire)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_advance)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_char_reg <= character;
            s1_has_reg  <= has_character;
            s1_last_reg <= last;
        end
    end

    // scan state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg         <= SCAN_RESET;
            char_count_reg <= '0;
        end
        else if (s1_advance)
        begin
            st_reg         <= st_next;
            char_count_reg <= char_count_next;
        end
    end

    // result register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (s1_advance && s1_last_reg)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_advance && s1_last_reg)
        begin
            out_reg <= verdict;
        end
    end

    assign out_valid  = out_valid_reg;
    assign address_ok = out_reg.address_ok;
    assign error_kind = out_reg.error_kind;

`ifndef NO_ASSERTIONS
    // a verdict says ok exactly when it carries no error code
    a_ok_matches_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (address_ok == (error_kind == ERR_NONE)))
        else $error("address_ok disagrees with error_kind");

    // the scan state restarts after each string end
    a_restart_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_advance && s1_last_reg) |=>
        (st_reg == SCAN_RESET) && (char_count_reg == '0))
        else $error("scan state not restarted after last item");

    // character count never passes its saturation point
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        char_count_reg <= CW'(MAX_CHARS + 1))
        else $error("character count out of range");

    // a stalled last item blocks new input
    a_block_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && s1_last_reg && out_valid_reg && !out_ready) |-> !in_ready)
        else $error("input accepted while a verdict is stalled");
`endif

endmodule

`default_nettype wire
